// ===== rtl/core/ntcsr_pkg.sv =====
package ntcsr_pkg;

   localparam int unsigned CHANNELS_DEF      = 2;
   localparam int unsigned TABLE_ENTRIES_DEF = 167;
   localparam int unsigned ROM_SIZE          = 167;
   localparam int unsigned QUEUE_DEPTH       = 2;

   localparam int unsigned RES_W   = 16;
   localparam int unsigned ROM_W   = 20;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned TEMP_W  = 10;
   localparam int unsigned CFG_W   = 8;
   localparam int unsigned CSR_A_W = 1;

   localparam logic signed [CFG_W-1:0] DEGREE_OFFSET_RST = -8'sd55;
   localparam logic [CFG_W-1:0]        JUMP_LIMIT_RST    = 8'd15;

   // register indexes on the csr port
   localparam logic [CSR_A_W-1:0] CSR_DEGREE_OFFSET = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_JUMP_LIMIT    = 1'b1;

   typedef struct packed {
      logic             usable;
      logic             channel;
      logic [RES_W-1:0] resistance;
   } item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CLAMP,
      B_SEARCH,
      B_RAW,
      B_APPLY
   } back_state_type;

   // descending resistance table, entries past the stored ones read as zero
   function automatic logic [ROM_W-1:0] rom_read(input logic [IDX_W-1:0] i);
      logic [ROM_W-1:0] v;
      unique case (i)
         8'd0:   v = 20'h6F7A6;  8'd1:   v = 20'h68047;  8'd2:   v = 20'h60EA9;
         8'd3:   v = 20'h5A35F;  8'd4:   v = 20'h53EE9;  8'd5:   v = 20'h4E181;
         8'd6:   v = 20'h48B19;  8'd7:   v = 20'h43B6A;  8'd8:   v = 20'h3F207;
         8'd9:   v = 20'h3AE72;  8'd10:  v = 20'h37026;  8'd11:  v = 20'h336A2;
         8'd12:  v = 20'h30171;  8'd13:  v = 20'h2D027;  8'd14:  v = 20'h2A266;
         8'd15:  v = 20'h277DD;  8'd16:  v = 20'h25046;  8'd17:  v = 20'h22B62;
         8'd18:  v = 20'h208FC;  8'd19:  v = 20'h1E8E4;  8'd20:  v = 20'h1CAF0;
         8'd21:  v = 20'h1AEF9;  8'd22:  v = 20'h194DD;  8'd23:  v = 20'h17C7A;
         8'd24:  v = 20'h165B3;  8'd25:  v = 20'h1506B;  8'd26:  v = 20'h13C88;
         8'd27:  v = 20'h129F2;  8'd28:  v = 20'h11891;  8'd29:  v = 20'h1084E;
         8'd30:  v = 20'h0F917;  8'd31:  v = 20'h0EAD9;  8'd32:  v = 20'h0DD80;
         8'd33:  v = 20'h0D0FE;  8'd34:  v = 20'h0C544;  8'd35:  v = 20'h0BA42;
         8'd36:  v = 20'h0AFEE;  8'd37:  v = 20'h0A63A;  8'd38:  v = 20'h09D1C;
         8'd39:  v = 20'h09489;  8'd40:  v = 20'h08C7A;  8'd41:  v = 20'h084E4;
         8'd42:  v = 20'h07DC1;  8'd43:  v = 20'h07709;  8'd44:  v = 20'h070B5;
         8'd45:  v = 20'h06ABF;  8'd46:  v = 20'h06522;  8'd47:  v = 20'h05FD7;
         8'd48:  v = 20'h05ADA;  8'd49:  v = 20'h05627;  8'd50:  v = 20'h051B8;
         8'd51:  v = 20'h04D8A;  8'd52:  v = 20'h04999;  8'd53:  v = 20'h045E1;
         8'd54:  v = 20'h0425F;  8'd55:  v = 20'h03F0F;  8'd56:  v = 20'h03BEF;
         8'd57:  v = 20'h038FC;  8'd58:  v = 20'h03632;  8'd59:  v = 20'h03391;
         8'd60:  v = 20'h03114;  8'd61:  v = 20'h02EBA;  8'd62:  v = 20'h02C81;
         8'd63:  v = 20'h02A67;  8'd64:  v = 20'h0286A;  8'd65:  v = 20'h02687;
         8'd66:  v = 20'h024BF;  8'd67:  v = 20'h0230F;  8'd68:  v = 20'h02175;
         8'd69:  v = 20'h01FF0;  8'd70:  v = 20'h01E80;  8'd71:  v = 20'h01D22;
         8'd72:  v = 20'h01BD7;  8'd73:  v = 20'h01A9B;  8'd74:  v = 20'h01970;
         8'd75:  v = 20'h01853;  8'd76:  v = 20'h01745;  8'd77:  v = 20'h01643;
         8'd78:  v = 20'h0154F;  8'd79:  v = 20'h01465;  8'd80:  v = 20'h01388;
         8'd81:  v = 20'h012B4;  8'd82:  v = 20'h011EB;  8'd83:  v = 20'h0112B;
         8'd84:  v = 20'h01074;  8'd85:  v = 20'h00FC5;  8'd86:  v = 20'h00F1E;
         8'd87:  v = 20'h00E80;  8'd88:  v = 20'h00DE8;  8'd89:  v = 20'h00D57;
         8'd90:  v = 20'h00CCD;  8'd91:  v = 20'h00C49;  8'd92:  v = 20'h00BCB;
         8'd93:  v = 20'h00B52;  8'd94:  v = 20'h00ADF;  8'd95:  v = 20'h00A71;
         8'd96:  v = 20'h00A08;  8'd97:  v = 20'h009A4;  8'd98:  v = 20'h00944;
         8'd99:  v = 20'h008E8;  8'd100: v = 20'h00890;  8'd101: v = 20'h0083C;
         8'd102: v = 20'h007EC;  8'd103: v = 20'h0079F;  8'd104: v = 20'h00755;
         8'd105: v = 20'h0070F;  8'd106: v = 20'h006CB;  8'd107: v = 20'h0068B;
         8'd108: v = 20'h0064D;  8'd109: v = 20'h00611;  8'd110: v = 20'h005D9;
         8'd111: v = 20'h005A2;  8'd112: v = 20'h0056E;  8'd113: v = 20'h0053C;
         8'd114: v = 20'h0050D;  8'd115: v = 20'h004DF;  8'd116: v = 20'h004B3;
         8'd117: v = 20'h00489;  8'd118: v = 20'h00460;  8'd119: v = 20'h00439;
         8'd120: v = 20'h00414;  8'd121: v = 20'h003F0;  8'd122: v = 20'h003CE;
         8'd123: v = 20'h003AD;  8'd124: v = 20'h0038D;  8'd125: v = 20'h0036E;
         8'd126: v = 20'h00351;  8'd127: v = 20'h00335;  8'd128: v = 20'h0031A;
         8'd129: v = 20'h00300;  8'd130: v = 20'h002E7;  8'd131: v = 20'h002CE;
         8'd132: v = 20'h002B7;  8'd133: v = 20'h002A1;  8'd134: v = 20'h0028B;
         8'd135: v = 20'h00276;  8'd136: v = 20'h00262;  8'd137: v = 20'h0024F;
         8'd138: v = 20'h0023D;  8'd139: v = 20'h0022B;  8'd140: v = 20'h00219;
         8'd141: v = 20'h00209;  8'd142: v = 20'h001F9;  8'd143: v = 20'h001E9;
         8'd144: v = 20'h001DA;  8'd145: v = 20'h001CC;  8'd146: v = 20'h001BE;
         8'd147: v = 20'h001B0;  8'd148: v = 20'h001A3;  8'd149: v = 20'h00196;
         8'd150: v = 20'h0018A;  8'd151: v = 20'h0017F;  8'd152: v = 20'h00173;
         8'd153: v = 20'h00168;  8'd154: v = 20'h0015E;  8'd155: v = 20'h00153;
         8'd156: v = 20'h0014A;  8'd157: v = 20'h00140;  8'd158: v = 20'h00137;
         8'd159: v = 20'h0012E;  8'd160: v = 20'h00125;  8'd161: v = 20'h0011D;
         8'd162: v = 20'h00115;  8'd163: v = 20'h0010D;  8'd164: v = 20'h00105;
         8'd165: v = 20'h000FE;  8'd166: v = 20'h000F7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/ntcsr_front.sv =====
module ntcsr_front #(
   parameter int unsigned CHANNELS = ntcsr_pkg::CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_channel,
   input  logic [ntcsr_pkg::RES_W-1:0] req_resistance,
   input  logic                       req_reading_ok,
   input  logic                       q_pop,
   output logic                       q_valid,
   output ntcsr_pkg::item_type        q_item
);
   import ntcsr_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;
   item_type           incoming;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   // classify on entry: bad reads and unknown channels skip the search
   always_comb begin
      incoming.channel    = req_channel;
      incoming.resistance = req_resistance;
      incoming.usable     = req_reading_ok && (int'(req_channel) < int'(CHANNELS));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== rtl/core/ntcsr_back.sv =====
module ntcsr_back #(
   parameter int unsigned CHANNELS      = ntcsr_pkg::CHANNELS_DEF,
   parameter int unsigned TABLE_ENTRIES = ntcsr_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ntcsr_pkg::item_type               q_item,
   output logic                              q_pop,
   input  logic signed [ntcsr_pkg::CFG_W-1:0] degree_offset,
   input  logic [ntcsr_pkg::CFG_W-1:0]        jump_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ntcsr_pkg::TEMP_W-1:0] rsp_temperature,
   output logic [ntcsr_pkg::IDX_W-1:0]        rsp_table_index,
   output logic                              rsp_spike_rejected
);
   import ntcsr_pkg::*;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

   back_state_type            state_ff, state_in;
   item_type                  item_ff, item_in;
   logic [IDX_W-1:0]          lo_ff, lo_in;
   logic [IDX_W-1:0]          hi_ff, hi_in;
   logic signed [TEMP_W-1:0]  raw_ff, raw_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  temp_ff, temp_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      rej_ff, rej_in;

   logic signed [TEMP_W-1:0]  prev_ff [CHANNELS];
   logic signed [TEMP_W-1:0]  prev_in [CHANNELS];
   logic signed [TEMP_W-1:0]  held_ff [CHANNELS];
   logic signed [TEMP_W-1:0]  held_in [CHANNELS];
   logic                      first_ff [CHANNELS];
   logic                      first_in [CHANNELS];

   logic [ROM_W-1:0]          res_ext;
   logic [IDX_W-1:0]          mid;
   logic                      out_free;
   logic signed [TEMP_W-1:0]  prev_sel;
   logic signed [TEMP_W-1:0]  held_sel;
   logic                      first_sel;
   logic signed [TEMP_W:0]    diff;
   logic [TEMP_W:0]           jump_size;
   logic                      spike;
   logic signed [TEMP_W-1:0]  held_new;

   assign res_ext  = ROM_W'(item_ff.resistance);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      prev_sel  = '0;
      held_sel  = '0;
      first_sel = 1'b0;
      for (int c = 0; c < int'(CHANNELS); c++) begin
         if (c == int'(item_ff.channel)) begin
            prev_sel  = prev_ff[c];
            held_sel  = held_ff[c];
            first_sel = first_ff[c];
         end
      end
   end

   always_comb begin
      diff      = {prev_sel[TEMP_W-1], prev_sel} - {raw_ff[TEMP_W-1], raw_ff};
      jump_size = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : (TEMP_W+1)'(diff);
      spike     = !first_sel && (jump_size >= (TEMP_W+1)'(jump_limit));
      held_new  = spike ? held_sel : raw_ff;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      raw_in       = raw_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      temp_in      = temp_ff;
      idx_in       = idx_ff;
      rej_in       = rej_ff;
      for (int c = 0; c < int'(CHANNELS); c++) begin
         prev_in[c]  = prev_ff[c];
         held_in[c]  = held_ff[c];
         first_in[c] = first_ff[c];
      end

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = q_item.usable ? B_CLAMP : B_APPLY;
            end
         end
         B_CLAMP: begin
            priority if (res_ext > rom_read('0)) begin
               lo_in    = '0;
               state_in = B_RAW;
            end else if (res_ext <= rom_read(LAST)) begin
               lo_in    = LAST;
               state_in = B_RAW;
            end else begin
               lo_in    = '0;
               hi_in    = LAST;
               state_in = B_SEARCH;
            end
         end
         B_SEARCH: begin
            // keep rom[lo] >= r and rom[hi] < r, halve the span each step
            if ((hi_ff - lo_ff) > IDX_W'(1)) begin
               if (rom_read(mid) >= res_ext) begin
                  lo_in = mid;
               end else begin
                  hi_in = mid;
               end
            end else begin
               state_in = B_RAW;
            end
         end
         B_RAW: begin
            raw_in   = $signed({2'b00, lo_ff}) + TEMP_W'(degree_offset);
            state_in = B_APPLY;
         end
         B_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (item_ff.usable) begin
                  temp_in = held_new;
                  idx_in  = lo_ff;
                  rej_in  = spike;
                  for (int c = 0; c < int'(CHANNELS); c++) begin
                     if (c == int'(item_ff.channel)) begin
                        prev_in[c]  = raw_ff;
                        held_in[c]  = held_new;
                        first_in[c] = 1'b0;
                     end
                  end
               end else begin
                  temp_in = '0;
                  idx_in  = '0;
                  rej_in  = 1'b0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < int'(CHANNELS); c++) begin
            prev_ff[c]  <= '0;
            held_ff[c]  <= '0;
            first_ff[c] <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < int'(CHANNELS); c++) begin
            prev_ff[c]  <= prev_in[c];
            held_ff[c]  <= held_in[c];
            first_ff[c] <= first_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      raw_ff  <= raw_in;
      temp_ff <= temp_in;
      idx_ff  <= idx_in;
      rej_ff  <= rej_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temperature    = temp_ff;
   assign rsp_table_index    = idx_ff;
   assign rsp_spike_rejected = rej_ff;

endmodule

// ===== rtl/core/ntc_table_temp_with_spike_reject_top.sv =====
// A failed reading goes straight to the output step; a good one gets a clamp
// check at the table ends, then, unless it clamps, a binary search of up to
// eight halving steps and one exit check, then the raw temperature and filter
// steps. The back end works on one item at a time and its search reads the
// resistance table once per step. A 2-entry input queue takes new items while
// one is in work or a result waits. Synchronous active-high reset clears the
// queue, the output register and the per-channel filter state.
module ntc_table_temp_with_spike_reject_top #(
   parameter int unsigned CHANNELS      = ntcsr_pkg::CHANNELS_DEF,
   parameter int unsigned TABLE_ENTRIES = ntcsr_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_channel,
   input  logic [ntcsr_pkg::RES_W-1:0]          req_resistance,
   input  logic                                req_reading_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ntcsr_pkg::TEMP_W-1:0]  rsp_temperature,
   output logic [ntcsr_pkg::IDX_W-1:0]          rsp_table_index,
   output logic                                rsp_spike_rejected,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ntcsr_pkg::CSR_A_W-1:0]        csr_index,
   input  logic [ntcsr_pkg::CFG_W-1:0]          csr_wdata
);
   import ntcsr_pkg::*;

   logic signed [CFG_W-1:0] degree_offset_ff;
   logic [CFG_W-1:0]        jump_limit_ff;
   logic                    q_valid;
   logic                    q_pop;
   item_type                q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_offset_ff <= DEGREE_OFFSET_RST;
         jump_limit_ff    <= JUMP_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEGREE_OFFSET: degree_offset_ff <= csr_wdata;
            CSR_JUMP_LIMIT:    jump_limit_ff    <= csr_wdata;
         endcase
      end
   end

   ntcsr_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_channel    (req_channel),
      .req_resistance (req_resistance),
      .req_reading_ok (req_reading_ok),
      .q_pop          (q_pop),
      .q_valid        (q_valid),
      .q_item         (q_item)
   );

   ntcsr_back #(
      .CHANNELS      (CHANNELS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .degree_offset      (degree_offset_ff),
      .jump_limit         (jump_limit_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_temperature    (rsp_temperature),
      .rsp_table_index    (rsp_table_index),
      .rsp_spike_rejected (rsp_spike_rejected)
   );

`ifndef ASSERT_OFF
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_table_index) < int'(TABLE_ENTRIES)))
      else $error("table index beyond last entry");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_table_index) && $stable(rsp_spike_rejected)))
      else $error("stalled result changed");
`endif

endmodule

// ===== tb/ntc_table_temp_with_spike_reject_top_tb.sv =====
`timescale 1ns / 100ps

module ntc_table_temp_with_spike_reject_top_tb;
   import ntcsr_pkg::*;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [IDX_W-1:0]         table_index;
      logic                     spike_rejected;
   } reading_result_type;

   localparam int NUM_CH   = 2;
   localparam int NUM_RES  = 167;
   localparam int LAST_IDX = NUM_RES - 1;
   // lowest index a 16-bit resistance can reach
   localparam int MIN_REACH = 29;

   class reading_scoreboard;
      logic [ROM_W-1:0]  res_table [NUM_RES];
      logic signed [7:0] degree_offset;
      logic [7:0]        jump_limit;
      int                last_raw [NUM_CH];
      int                held_temp [NUM_CH];
      bit                awaiting_first [NUM_CH];
      reading_result_type expected_q [$];
      int                failures;

      function new();
         res_table = '{
            20'h6F7A6, 20'h68047, 20'h60EA9, 20'h5A35F, 20'h53EE9, 20'h4E181, 20'h48B19,
            20'h43B6A, 20'h3F207, 20'h3AE72, 20'h37026, 20'h336A2, 20'h30171, 20'h2D027,
            20'h2A266, 20'h277DD, 20'h25046, 20'h22B62, 20'h208FC, 20'h1E8E4, 20'h1CAF0,
            20'h1AEF9, 20'h194DD, 20'h17C7A, 20'h165B3, 20'h1506B, 20'h13C88, 20'h129F2,
            20'h11891, 20'h1084E, 20'h0F917, 20'h0EAD9, 20'h0DD80, 20'h0D0FE, 20'h0C544,
            20'h0BA42, 20'h0AFEE, 20'h0A63A, 20'h09D1C, 20'h09489, 20'h08C7A, 20'h084E4,
            20'h07DC1, 20'h07709, 20'h070B5, 20'h06ABF, 20'h06522, 20'h05FD7, 20'h05ADA,
            20'h05627, 20'h051B8, 20'h04D8A, 20'h04999, 20'h045E1, 20'h0425F, 20'h03F0F,
            20'h03BEF, 20'h038FC, 20'h03632, 20'h03391, 20'h03114, 20'h02EBA, 20'h02C81,
            20'h02A67, 20'h0286A, 20'h02687, 20'h024BF, 20'h0230F, 20'h02175, 20'h01FF0,
            20'h01E80, 20'h01D22, 20'h01BD7, 20'h01A9B, 20'h01970, 20'h01853, 20'h01745,
            20'h01643, 20'h0154F, 20'h01465, 20'h01388, 20'h012B4, 20'h011EB, 20'h0112B,
            20'h01074, 20'h00FC5, 20'h00F1E, 20'h00E80, 20'h00DE8, 20'h00D57, 20'h00CCD,
            20'h00C49, 20'h00BCB, 20'h00B52, 20'h00ADF, 20'h00A71, 20'h00A08, 20'h009A4,
            20'h00944, 20'h008E8, 20'h00890, 20'h0083C, 20'h007EC, 20'h0079F, 20'h00755,
            20'h0070F, 20'h006CB, 20'h0068B, 20'h0064D, 20'h00611, 20'h005D9, 20'h005A2,
            20'h0056E, 20'h0053C, 20'h0050D, 20'h004DF, 20'h004B3, 20'h00489, 20'h00460,
            20'h00439, 20'h00414, 20'h003F0, 20'h003CE, 20'h003AD, 20'h0038D, 20'h0036E,
            20'h00351, 20'h00335, 20'h0031A, 20'h00300, 20'h002E7, 20'h002CE, 20'h002B7,
            20'h002A1, 20'h0028B, 20'h00276, 20'h00262, 20'h0024F, 20'h0023D, 20'h0022B,
            20'h00219, 20'h00209, 20'h001F9, 20'h001E9, 20'h001DA, 20'h001CC, 20'h001BE,
            20'h001B0, 20'h001A3, 20'h00196, 20'h0018A, 20'h0017F, 20'h00173, 20'h00168,
            20'h0015E, 20'h00153, 20'h0014A, 20'h00140, 20'h00137, 20'h0012E, 20'h00125,
            20'h0011D, 20'h00115, 20'h0010D, 20'h00105, 20'h000FE, 20'h000F7};
         degree_offset = -8'sd55;
         jump_limit    = 8'd15;
         for (int c = 0; c < NUM_CH; c++) begin
            last_raw[c]       = 0;
            held_temp[c]      = 0;
            awaiting_first[c] = 1'b1;
         end
         failures = 0;
      endfunction

      function void set_register(logic [CSR_A_W-1:0] index, logic [7:0] value);
         if (index == CSR_DEGREE_OFFSET)
            degree_offset = value;
         else
            jump_limit = value;
      endfunction

      // last entry at or above r, clamped at both ends of the table
      function int table_position(logic [RES_W-1:0] r);
         logic [ROM_W-1:0] rr;
         int lo, hi, mid;
         rr = ROM_W'(r);
         if (rr > res_table[0])
            return 0;
         if (rr <= res_table[LAST_IDX])
            return LAST_IDX;
         lo = 0;
         hi = LAST_IDX;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (res_table[mid] >= rr)
               lo = mid;
            else
               hi = mid;
         end
         return lo;
      endfunction

      function void note_reading(logic ch, logic [RES_W-1:0] r, logic ok);
         reading_result_type e;
         int idx, raw, diff;
         e = '0;
         if (ok) begin
            idx = table_position(r);
            raw = idx + int'(degree_offset);
            if (awaiting_first[ch]) begin
               held_temp[ch]      = raw;
               awaiting_first[ch] = 1'b0;
            end else begin
               diff = last_raw[ch] - raw;
               if (diff < 0)
                  diff = -diff;
               if (diff >= int'(jump_limit))
                  e.spike_rejected = 1'b1;
               else
                  held_temp[ch] = raw;
            end
            last_raw[ch]  = raw;
            e.temperature = TEMP_W'(held_temp[ch]);
            e.table_index = IDX_W'(idx);
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(reading_result_type got);
         reading_result_type e;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected beat temp=%0d idx=%0d rej=%0b", $realtime,
                        got.temperature, got.table_index, got.spike_rejected);
            return;
         end
         e = expected_q.pop_front();
         if (got.temperature !== e.temperature || got.table_index !== e.table_index ||
             got.spike_rejected !== e.spike_rejected) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch exp temp=%0d idx=%0d rej=%0b, got temp=%0d idx=%0d rej=%0b",
                        $realtime, e.temperature, e.table_index, e.spike_rejected,
                        got.temperature, got.table_index, got.spike_rejected);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_channel    = 1'b0;
   logic [RES_W-1:0]         req_resistance = '0;
   logic                     req_reading_ok = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic [IDX_W-1:0]         rsp_table_index;
   logic                     rsp_spike_rejected;
   logic                     csr_valid      = 1'b0;
   logic                     csr_ready;
   logic [CSR_A_W-1:0]       csr_index      = '0;
   logic [CFG_W-1:0]         csr_wdata      = '0;

   reading_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int drift_idx [NUM_CH] = '{60, 100};

   ntc_table_temp_with_spike_reject_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel        (req_channel),
      .req_resistance     (req_resistance),
      .req_reading_ok     (req_reading_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_temperature    (rsp_temperature),
      .rsp_table_index    (rsp_table_index),
      .rsp_spike_rejected (rsp_spike_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_temperature, rsp_table_index, rsp_spike_rejected});
   end

   task send_reading(input logic ch, input logic [RES_W-1:0] r, input logic ok);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_channel    <= ch;
      req_resistance <= r;
      req_reading_ok <= ok;
      do @(posedge clock); while (req_stall);
      sb.note_reading(ch, r, ok);
      @(negedge clock);
   endtask

   // hold the sender until every outstanding beat has come back
   task wait_for_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(negedge clock);
   endtask

   task apply_settings(input logic [7:0] offset, input logic [7:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEGREE_OFFSET;
      csr_wdata <= offset;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_DEGREE_OFFSET, offset);
      @(negedge clock);
      csr_index <= CSR_JUMP_LIMIT;
      csr_wdata <= limit;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_JUMP_LIMIT, limit);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // any resistance that lands on table index i
   function automatic logic [RES_W-1:0] res_for_index(int i);
      int lo, hi;
      lo = (i == LAST_IDX) ? 0 : int'(sb.res_table[i+1]) + 1;
      hi = (sb.res_table[i] > 20'hFFFF) ? 32'hFFFF : int'(sb.res_table[i]);
      return RES_W'($urandom_range(hi, lo));
   endfunction

   task random_readings(input int count);
      int kind, span, i;
      logic ch;
      logic [RES_W-1:0] r;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         ch   = 1'($urandom_range(0, 1));
         if (kind < 8) begin
            send_reading(ch, RES_W'($urandom()), 1'b0);
         end else if (kind < 20) begin
            send_reading(ch, RES_W'($urandom()), 1'b1);
         end else if (kind < 28) begin
            // land on or next to a table entry
            i = $urandom_range(MIN_REACH, LAST_IDX);
            if (i == MIN_REACH)
               r = 16'hFFFF;
            else
               r = RES_W'(int'(sb.res_table[i]) + int'($urandom_range(0, 2)) - 1);
            send_reading(ch, r, 1'b1);
         end else begin
            // drift around the last reading, now and then with a large jump
            span = ($urandom_range(0, 9) == 0) ? 140 : $urandom_range(1, 20);
            drift_idx[ch] += $urandom_range(0, 2 * span) - span;
            if (drift_idx[ch] < MIN_REACH)
               drift_idx[ch] = MIN_REACH;
            if (drift_idx[ch] > LAST_IDX)
               drift_idx[ch] = LAST_IDX;
            send_reading(ch, res_for_index(drift_idx[ch]), 1'b1);
         end
         if ($urandom_range(0, 199) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 65;

      // reset settings: failed reads, first reads, clamps, limit edges
      send_reading(1'b0, 16'h0000, 1'b0);
      send_reading(1'b0, 16'hFFFF, 1'b1);
      send_reading(1'b0, sb.res_table[30][RES_W-1:0], 1'b1);
      send_reading(1'b0, sb.res_table[30][RES_W-1:0] + 16'd1, 1'b1);
      send_reading(1'b0, 16'h0000, 1'b1);
      send_reading(1'b0, sb.res_table[LAST_IDX][RES_W-1:0], 1'b1);
      send_reading(1'b0, sb.res_table[LAST_IDX][RES_W-1:0] + 16'd1, 1'b1);
      send_reading(1'b1, 16'hFFFF, 1'b0);
      send_reading(1'b1, sb.res_table[55][RES_W-1:0], 1'b1);
      send_reading(1'b1, sb.res_table[55][RES_W-1:0] + 16'd1, 1'b1);
      send_reading(1'b1, sb.res_table[70][RES_W-1:0], 1'b1);
      send_reading(1'b1, sb.res_table[55][RES_W-1:0], 1'b1);
      send_reading(1'b1, sb.res_table[69][RES_W-1:0], 1'b1);
      send_reading(1'b0, 16'hFFFF, 1'b0);
      send_reading(1'b0, 16'h8000, 1'b1);
      send_reading(1'b1, 16'h0001, 1'b1);
      send_reading(1'b0, sb.res_table[100][RES_W-1:0], 1'b1);
      send_reading(1'b1, 16'h5555, 1'b1);
      send_reading(1'b0, 16'hAAAA, 1'b1);
      wait_for_results();

      apply_settings(8'h80, 8'd1);
      random_readings(320);
      wait_for_results();
      apply_settings(8'h7F, 8'd255);
      random_readings(320);
      wait_for_results();

      send_idle_pct = 65;
      recv_idle_pct = 24;
      // zero limit rejects everything after the first reading
      apply_settings(8'h00, 8'd0);
      random_readings(330);
      wait_for_results();
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)));
      random_readings(330);
      wait_for_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(8'hC9, 8'd15);
      random_readings(320);
      wait_for_results();
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_readings(330);
      wait_for_results();

      repeat (16) @(negedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ntcsr_pkg.sv
rtl/core/ntcsr_front.sv
rtl/core/ntcsr_back.sv
rtl/core/ntc_table_temp_with_spike_reject_top.sv
tb/ntc_table_temp_with_spike_reject_top_tb.sv
